// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/sdspi_pkg.sv =====
package sdspi_pkg;
    // Phases of the byte-exchange sequencer.
    localparam logic [4:0] P_IDLE = 5'd0, P_CLK = 5'd1, P_DESEL = 5'd2, P_RDY = 5'd3,
        P_FAILDESEL = 5'd4, P_CMD = 5'd5, P_STUFF = 5'd6, P_R1 = 5'd7, P_TAIL = 5'd8,
        P_TOKEN = 5'd9, P_DATA = 5'd10, P_RCRC = 5'd11, P_WRDY = 5'd12, P_WDATA = 5'd13,
        P_WCRC = 5'd14, P_WRESP = 5'd15, P_STOP = 5'd16, P_FINAL = 5'd17;
    // Continuation points after a command or a block.
    localparam logic [4:0] K_CMD0 = 5'd0, K_CMD8 = 5'd1, K_CMD8TAIL = 5'd2,
        K_V2_55 = 5'd3, K_V2_41 = 5'd4, K_CMD58 = 5'd5, K_OCR = 5'd6, K_V1_55A = 5'd7,
        K_V1_41A = 5'd8, K_V1_55 = 5'd9, K_V1_41 = 5'd10, K_MMC1 = 5'd11,
        K_CMD16 = 5'd12, K_CMD9 = 5'd13, K_CSD = 5'd14, K_RD1 = 5'd15,
        K_RDBLK1 = 5'd16, K_CMD18 = 5'd17, K_RDBLKM = 5'd18, K_CMD12 = 5'd19,
        K_W55 = 5'd20, K_W23 = 5'd21, K_CMD24 = 5'd22, K_WBLK1 = 5'd23,
        K_CMD25 = 5'd24, K_WBLKM = 5'd25, K_WSTOP = 5'd26;
    // Request codes.
    localparam logic [2:0] F_BYTE = 3'd0, F_INIT = 3'd1, F_READ = 3'd2,
        F_WRITE = 3'd3, F_CAP = 3'd4;
    // Status codes.
    localparam logic [2:0] S_OK = 3'd0, S_RDY_TO = 3'd1, S_NO_TOKEN = 3'd2,
        S_CMD_REJ = 3'd3, S_WR_REJ = 3'd4, S_INIT_FAIL = 3'd5;
    // Card types.
    localparam logic [2:0] C_ERR = 3'd0, C_MMC = 3'd1, C_SD1 = 3'd2, C_SD2 = 3'd3,
        C_SDHC = 3'd4;
    // Register indexes.
    localparam logic [2:0] R_READY_WAIT = 3'd0, R_TOKEN_WAIT = 3'd1, R_INIT_RETRY = 3'd2,
        R_RESET_TRIES = 3'd3, R_R1_POLL = 3'd4;
    localparam logic [7:0] TOK_SINGLE = 8'hFE, TOK_MULTI = 8'hFC, TOK_STOP = 8'hFD;
    localparam logic [27:0] MAX_SECTORS = 28'd134217728;

    // One result item.
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        spi_fast;
        logic [7:0]  read_data;
        logic        read_valid;
        logic        block_last;
        logic        write_wanted;
        logic        done_res;
        logic [2:0]  status;
        logic [2:0]  card_type;
        logic [7:0]  last_response;
        logic [27:0] sector_count;
    } t_result;

    // Decode the sector count from a 16-byte CSD.
    function automatic logic [27:0] csd_sectors(input logic [7:0] c [16]);
        logic [22:0] v2;
        logic [4:0]  n;
        logic [12:0] cs;
        logic [40:0] wide;
        begin
            v2 = {1'b0, c[7][5:0], c[8], c[9]} + 23'd1;
            n = {1'b0, c[5][3:0]} + {4'd0, c[10][7]} + {2'd0, c[9][1:0], 1'b0} + 5'd2;
            cs = {1'b0, c[6][1:0], c[7], c[8][7:6]} + 13'd1;
            if (c[0][7:6] == 2'b01) begin
                wide = {8'd0, v2, 10'd0};
            end else if (n >= 5'd9) begin
                wide = {28'd0, cs} << (n - 5'd9);
            end else begin
                wide = {28'd0, cs} >> (5'd9 - n);
            end
            csd_sectors = (wide > {13'd0, MAX_SECTORS}) ? MAX_SECTORS : wide[27:0];
        end
    endfunction
endpackage

// ===== rtl/sd_card_spi_host_controller.sv =====
// SD card host controller for SPI mode on top of a byte-exchange engine. Each input
// transaction is a request (init, read, write, capacity) or the byte the card returned
// from the last exchange; each one yields exactly one result transaction giving the
// next byte to send plus read data, status, card type and last R1. An input is taken
// every cycle through one result register while the output is free or being drained;
// the SPI exchange time itself sets the real throughput.
// During a block write, a result with write_wanted set asks for write_byte in the next
// byte input. Data CRC bytes are sent as 0xFF and never checked.
module sd_card_spi_host_controller
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_sector,
    input  logic [7:0]  i_block_count,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_spi_fast,
    output logic [7:0]  o_read_data,
    output logic        o_read_valid,
    output logic        o_block_last,
    output logic        o_write_wanted,
    output logic        o_done_res,
    output logic [2:0]  o_status,
    output logic [2:0]  o_card_type,
    output logic [7:0]  o_last_response,
    output logic [27:0] o_sector_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
`include "assert_macros.svh"
    localparam int BW = $clog2(BLOCK_BYTES + 1);
    localparam logic [BW-1:0] BLEN = BW'(BLOCK_BYTES);

    // Configuration registers.
    logic [23:0] r_rdy_lim;
    logic [15:0] r_tok_lim, r_init_lim;
    logic [7:0]  r_rst_tries, r_r1_lim;

    // Sequencer state.
    logic [4:0]  r_phase, n_phase, r_ret, n_ret;
    logic [BW-1:0] r_bidx, n_bidx;
    logic [23:0] r_wait, n_wait;
    logic [15:0] r_retry, n_retry;
    logic [2:0]  r_kind, n_kind;
    logic [5:0]  r_cidx, n_cidx;
    logic [31:0] r_carg, n_carg, r_baddr, n_baddr;
    logic [7:0]  r_resp, n_resp, r_left, n_left, r_ptok, n_ptok;
    logic [2:0]  r_rstat, n_rstat, r_rfunc, n_rfunc;
    logic        r_fast, n_fast, r_cto, n_cto;
    logic [7:0]  r_csd [16];
    logic [7:0]  r_tail [4];
    logic        csd_we, tail_we;
    logic [3:0]  csd_wa;
    logic [1:0]  tail_wa;

    // Result register.
    logic        r_ovalid;
    t_result     r_out, n_out;
    logic        accept;

    assign o_ready = !r_ovalid || i_ready;
    assign accept = i_valid && o_ready;

    // Command frame byte k.
    function automatic logic [7:0] cmd_byte(input logic [BW-1:0] k, input logic [5:0] ci,
                                            input logic [31:0] arg);
        begin
            if (k == '0) cmd_byte = {2'b01, ci};
            else if (k == BW'(1)) cmd_byte = arg[31:24];
            else if (k == BW'(2)) cmd_byte = arg[23:16];
            else if (k == BW'(3)) cmd_byte = arg[15:8];
            else if (k == BW'(4)) cmd_byte = arg[7:0];
            else if (ci == 6'd0) cmd_byte = 8'h95;
            else if (ci == 6'd8) cmd_byte = 8'h87;
            else cmd_byte = 8'h01;
        end
    endfunction

    always_comb begin
        logic [7:0]  rx;
        logic        do_cont;
        logic [7:0]  cr;
        logic [15:0] rdec;
        logic [BW-1:0] bnext;
        logic [7:0]  lnext;
        rx = i_rx_byte;
        do_cont = 1'b0;
        cr = 8'd0;
        rdec = 16'd0;
        bnext = '0;
        lnext = 8'd0;
        n_phase = r_phase; n_ret = r_ret; n_bidx = r_bidx; n_wait = r_wait;
        n_retry = r_retry; n_kind = r_kind; n_cidx = r_cidx; n_carg = r_carg;
        n_baddr = r_baddr; n_resp = r_resp; n_left = r_left; n_ptok = r_ptok;
        n_rstat = r_rstat; n_rfunc = r_rfunc; n_fast = r_fast; n_cto = r_cto;
        csd_we = 1'b0; tail_we = 1'b0;
        csd_wa = r_bidx[3:0]; tail_wa = r_bidx[1:0];
        n_out = '0;

        if (i_func >= F_INIT && i_func <= F_CAP) begin
            // Start a new request, dropping any running one.
            n_rfunc = i_func;
            n_rstat = S_OK;
            n_baddr = (r_kind == C_SDHC) ? i_sector : {i_sector[22:0], 9'd0};
            n_left = i_block_count;
            n_out.tx_valid = 1'b1;
            n_out.tx_byte = 8'hFF;
            n_phase = P_DESEL;
            n_cto = 1'b0;
            n_carg = 32'd0;
            if (i_func == F_INIT) begin
                n_fast = 1'b0; n_kind = C_ERR; n_bidx = BW'(1); n_phase = P_CLK;
            end else if (i_func == F_CAP) begin
                n_cidx = 6'd9; n_ret = K_CMD9;
            end else if (i_block_count == 8'd0) begin
                n_out.tx_valid = 1'b0; n_out.tx_byte = 8'd0;
                n_phase = P_IDLE; n_out.done_res = 1'b1;
            end else if (i_func == F_READ) begin
                n_carg = n_baddr;
                n_cidx = (i_block_count == 8'd1) ? 6'd17 : 6'd18;
                n_ret = (i_block_count == 8'd1) ? K_RD1 : K_CMD18;
            end else if (i_block_count == 8'd1) begin
                n_carg = n_baddr; n_cidx = 6'd24; n_ret = K_CMD24;
            end else if (r_kind >= C_SD1 && r_kind <= C_SDHC) begin
                n_cidx = 6'd55; n_ret = K_W55;
            end else begin
                n_carg = n_baddr; n_cidx = 6'd25; n_ret = K_CMD25;
            end
        end else if (r_phase != P_IDLE) begin
            // Advance the running request by one byte.
            n_out.tx_byte = 8'hFF;
            n_out.tx_valid = 1'b1;
            case (r_phase)
                P_CLK: begin
                    if (r_bidx < BW'(10)) begin
                        n_bidx = r_bidx + BW'(1);
                    end else begin
                        n_retry = 16'd0; n_cidx = 6'd0; n_carg = 32'd0; n_ret = K_CMD0;
                        n_cto = 1'b0; n_phase = P_DESEL;
                    end
                end
                P_DESEL: begin
                    n_wait = 24'd1; n_phase = P_RDY;
                end
                P_RDY: begin
                    if (rx == 8'hFF) begin
                        n_bidx = '0; n_phase = P_CMD;
                        n_out.tx_byte = cmd_byte('0, r_cidx, r_carg);
                    end else if (r_wait >= r_rdy_lim) begin
                        n_phase = P_FAILDESEL;
                    end else begin
                        n_wait = r_wait + 24'd1;
                    end
                end
                P_FAILDESEL: begin
                    n_cto = 1'b1; n_resp = 8'hFF; do_cont = 1'b1; cr = 8'hFF;
                end
                P_CMD: begin
                    if (r_bidx < BW'(5)) begin
                        n_bidx = r_bidx + BW'(1);
                        n_out.tx_byte = cmd_byte(r_bidx + BW'(1), r_cidx, r_carg);
                    end else if (r_cidx == 6'd12) begin
                        n_phase = P_STUFF;
                    end else begin
                        n_wait = 24'd1; n_phase = P_R1;
                    end
                end
                P_STUFF: begin
                    n_wait = 24'd1; n_phase = P_R1;
                end
                P_R1: begin
                    if (!rx[7] || r_wait >= {16'd0, r_r1_lim}) begin
                        n_resp = rx; do_cont = 1'b1; cr = rx;
                    end else begin
                        n_wait = r_wait + 24'd1;
                    end
                end
                P_TAIL: begin
                    tail_we = 1'b1;
                    n_bidx = r_bidx + BW'(1);
                    if (r_bidx >= BW'(3)) begin
                        do_cont = 1'b1;
                    end
                end
                P_TOKEN: begin
                    if (rx == TOK_SINGLE) begin
                        n_bidx = '0; n_phase = P_DATA;
                    end else if (r_wait >= {8'd0, r_tok_lim}) begin
                        do_cont = 1'b1; cr = 8'd1;
                    end else begin
                        n_wait = r_wait + 24'd1;
                    end
                end
                P_DATA: begin
                    bnext = r_bidx + BW'(1);
                    if (r_ret == K_CSD) begin
                        csd_we = 1'b1;
                        if (bnext >= BW'(16)) begin
                            n_bidx = '0; n_phase = P_RCRC;
                        end else begin
                            n_bidx = bnext;
                        end
                    end else begin
                        n_out.read_valid = 1'b1;
                        n_out.read_data = rx;
                        n_out.block_last = (bnext == BLEN);
                        if (bnext >= BLEN) begin
                            n_bidx = '0; n_phase = P_RCRC;
                        end else begin
                            n_bidx = bnext;
                        end
                    end
                end
                P_RCRC: begin
                    if (r_bidx == '0) n_bidx = BW'(1);
                    else do_cont = 1'b1;
                end
                P_WRDY: begin
                    if (rx == 8'hFF) begin
                        if (r_ptok == TOK_STOP) begin
                            n_phase = P_STOP; n_out.tx_byte = TOK_STOP;
                        end else begin
                            n_bidx = '0; n_phase = P_WDATA;
                            n_out.tx_byte = r_ptok; n_out.write_wanted = 1'b1;
                        end
                    end else if (r_wait >= r_rdy_lim) begin
                        do_cont = 1'b1; cr = 8'd1;
                    end else begin
                        n_wait = r_wait + 24'd1;
                    end
                end
                P_WDATA: begin
                    if (r_bidx < BLEN) begin
                        n_out.tx_byte = i_write_byte;
                        n_bidx = r_bidx + BW'(1);
                        n_out.write_wanted = (r_bidx + BW'(1)) < BLEN;
                    end else begin
                        n_bidx = '0; n_phase = P_WCRC;
                    end
                end
                P_WCRC: begin
                    if (r_bidx == '0) n_bidx = BW'(1);
                    else n_phase = P_WRESP;
                end
                P_WRESP: begin
                    do_cont = 1'b1;
                    cr = (rx[4:0] == 5'h05) ? 8'd0 : 8'd4;
                end
                P_STOP: begin
                    do_cont = 1'b1;
                end
                P_FINAL: begin
                    if (r_rfunc == F_INIT) n_fast = 1'b1;
                    n_out.tx_valid = 1'b0; n_out.tx_byte = 8'd0;
                    n_phase = P_IDLE; n_out.done_res = 1'b1; n_out.status = r_rstat;
                end
                default: begin
                    n_out.tx_valid = 1'b0; n_out.tx_byte = 8'd0;
                end
            endcase

            if (do_cont) begin
                // Continue the request after a command response or a block.
                n_out.tx_valid = 1'b1;
                n_out.tx_byte = 8'hFF;
                case (r_ret)
                    K_CMD0: begin
                        n_retry = r_retry + 16'd1;
                        if (cr == 8'h01) begin
                            n_cidx = 6'd8; n_carg = 32'h1AA; n_ret = K_CMD8;
                            n_cto = 1'b0; n_phase = P_DESEL;
                        end else if (n_retry >= {8'd0, r_rst_tries}) begin
                            n_kind = C_ERR; n_rstat = S_INIT_FAIL; n_phase = P_FINAL;
                        end else begin
                            n_cidx = 6'd0; n_carg = 32'd0; n_cto = 1'b0; n_phase = P_DESEL;
                        end
                    end
                    K_CMD8: begin
                        if (cr == 8'h01) begin
                            n_ret = K_CMD8TAIL; n_bidx = '0; n_phase = P_TAIL;
                        end else begin
                            n_cidx = 6'd55; n_carg = 32'd0; n_ret = K_V1_55A;
                            n_cto = 1'b0; n_phase = P_DESEL;
                        end
                    end
                    K_CMD8TAIL: begin
                        n_retry = r_init_lim;
                        if (r_tail[2] != 8'h01 || rx != 8'hAA || r_init_lim == 16'd0) begin
                            n_kind = C_ERR; n_rstat = S_INIT_FAIL; n_phase = P_FINAL;
                        end else begin
                            n_cidx = 6'd55; n_carg = 32'd0; n_ret = K_V2_55;
                            n_cto = 1'b0; n_phase = P_DESEL;
                        end
                    end
                    K_V2_55, K_V1_55A, K_V1_55: begin
                        n_cidx = 6'd41;
                        n_carg = (r_ret == K_V2_55) ? 32'h4000_0000 : 32'd0;
                        n_ret = (r_ret == K_V2_55) ? K_V2_41 :
                                (r_ret == K_V1_55A) ? K_V1_41A : K_V1_41;
                        n_cto = 1'b0; n_phase = P_DESEL;
                    end
                    K_V2_41, K_V1_41, K_MMC1: begin
                        rdec = r_retry - 16'd1;
                        if (cr == 8'd0) begin
                            n_cidx = (r_ret == K_V2_41) ? 6'd58 : 6'd16;
                            n_carg = (r_ret == K_V2_41) ? 32'd0 : 32'(BLOCK_BYTES);
                            n_ret = (r_ret == K_V2_41) ? K_CMD58 : K_CMD16;
                            n_cto = 1'b0; n_phase = P_DESEL;
                        end else begin
                            n_retry = rdec;
                            if (rdec == 16'd0) begin
                                n_kind = C_ERR; n_rstat = S_INIT_FAIL; n_phase = P_FINAL;
                            end else begin
                                n_cidx = (r_ret == K_MMC1) ? 6'd1 : 6'd55;
                                n_carg = 32'd0;
                                n_ret = (r_ret == K_V2_41) ? K_V2_55 :
                                        (r_ret == K_V1_41) ? K_V1_55 : K_MMC1;
                                n_cto = 1'b0; n_phase = P_DESEL;
                            end
                        end
                    end
                    K_CMD58: begin
                        if (cr == 8'd0) begin
                            n_ret = K_OCR; n_bidx = '0; n_phase = P_TAIL;
                        end else begin
                            n_kind = C_ERR; n_rstat = S_INIT_FAIL; n_phase = P_FINAL;
                        end
                    end
                    K_OCR: begin
                        n_kind = r_tail[0][6] ? C_SDHC : C_SD2;
                        n_rstat = S_OK; n_phase = P_FINAL;
                    end
                    K_V1_41A: begin
                        n_retry = r_init_lim;
                        n_kind = (cr <= 8'd1) ? C_SD1 : C_MMC;
                        if (r_init_lim == 16'd0) begin
                            n_kind = C_ERR; n_rstat = S_INIT_FAIL; n_phase = P_FINAL;
                        end else begin
                            n_cidx = (cr <= 8'd1) ? 6'd55 : 6'd1;
                            n_ret = (cr <= 8'd1) ? K_V1_55 : K_MMC1;
                            n_carg = 32'd0; n_cto = 1'b0; n_phase = P_DESEL;
                        end
                    end
                    K_CMD16: begin
                        if (cr != 8'd0) n_kind = C_ERR;
                        n_rstat = (cr != 8'd0 || r_kind == C_ERR) ? S_INIT_FAIL : S_OK;
                        n_phase = P_FINAL;
                    end
                    K_CMD9: begin
                        if (cr == 8'd0) begin
                            n_ret = K_CSD; n_wait = 24'd1; n_phase = P_TOKEN;
                        end else begin
                            n_out.tx_valid = 1'b0; n_out.tx_byte = 8'd0;
                            n_phase = P_IDLE; n_out.done_res = 1'b1;
                            n_out.status = n_cto ? S_RDY_TO : S_CMD_REJ;
                        end
                    end
                    K_CSD: begin
                        n_out.tx_valid = 1'b0; n_out.tx_byte = 8'd0;
                        n_phase = P_IDLE; n_out.done_res = 1'b1;
                        if (cr != 8'd0) n_out.status = S_NO_TOKEN;
                        else n_out.sector_count = csd_sectors(r_csd);
                    end
                    K_RD1, K_CMD18: begin
                        if (cr == 8'd0) begin
                            n_ret = (r_ret == K_RD1) ? K_RDBLK1 : K_RDBLKM;
                            n_wait = 24'd1; n_phase = P_TOKEN;
                        end else begin
                            n_rstat = n_cto ? S_RDY_TO : S_CMD_REJ; n_phase = P_FINAL;
                        end
                    end
                    K_RDBLK1: begin
                        n_rstat = (cr != 8'd0) ? S_NO_TOKEN : S_OK; n_phase = P_FINAL;
                    end
                    K_RDBLKM: begin
                        lnext = r_left - 8'd1;
                        if (cr == 8'd0) n_left = lnext;
                        if (cr == 8'd0 && lnext != 8'd0) begin
                            n_ret = K_RDBLKM; n_wait = 24'd1; n_phase = P_TOKEN;
                        end else begin
                            n_rstat = (cr != 8'd0) ? S_NO_TOKEN : S_OK;
                            n_cidx = 6'd12; n_carg = 32'd0; n_ret = K_CMD12;
                            n_cto = 1'b0; n_phase = P_DESEL;
                        end
                    end
                    K_CMD12: begin
                        n_phase = P_FINAL;
                    end
                    K_W55: begin
                        n_cidx = 6'd23; n_carg = {24'd0, r_left}; n_ret = K_W23;
                        n_cto = 1'b0; n_phase = P_DESEL;
                    end
                    K_W23: begin
                        n_cidx = 6'd25; n_carg = r_baddr; n_ret = K_CMD25;
                        n_cto = 1'b0; n_phase = P_DESEL;
                    end
                    K_CMD24, K_CMD25: begin
                        if (r_ret == K_CMD25) n_rstat = S_OK;
                        if (cr == 8'd0) begin
                            n_ret = (r_ret == K_CMD24) ? K_WBLK1 : K_WBLKM;
                            n_ptok = (r_ret == K_CMD24) ? TOK_SINGLE : TOK_MULTI;
                            n_wait = 24'd1; n_phase = P_WRDY;
                        end else begin
                            n_rstat = n_cto ? S_RDY_TO : S_CMD_REJ; n_phase = P_FINAL;
                        end
                    end
                    K_WBLK1: begin
                        n_rstat = cr[2:0]; n_phase = P_FINAL;
                    end
                    K_WBLKM: begin
                        lnext = r_left - 8'd1;
                        n_wait = 24'd1; n_phase = P_WRDY; n_ret = K_WSTOP;
                        n_ptok = TOK_STOP;
                        if (cr != 8'd0) begin
                            n_rstat = cr[2:0];
                        end else begin
                            n_left = lnext;
                            if (lnext != 8'd0) begin
                                n_ret = K_WBLKM; n_ptok = TOK_MULTI;
                            end
                        end
                    end
                    default: begin
                        if (r_rstat == S_OK) n_rstat = cr[2:0];
                        n_phase = P_FINAL;
                    end
                endcase
            end
        end

        n_out.spi_fast = n_fast;
        n_out.card_type = n_kind;
        n_out.last_response = n_resp;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy_lim <= 24'hFFFFFF;
            r_tok_lim <= 16'hFFFF;
            r_init_lim <= 16'hFFFE;
            r_rst_tries <= 8'd20;
            r_r1_lim <= 8'd31;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                R_READY_WAIT: r_rdy_lim <= i_cfg_data;
                R_TOKEN_WAIT: r_tok_lim <= i_cfg_data[15:0];
                R_INIT_RETRY: r_init_lim <= i_cfg_data[15:0];
                R_RESET_TRIES: r_rst_tries <= i_cfg_data[7:0];
                R_R1_POLL: r_r1_lim <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Advance state on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_ret <= K_CMD0; r_bidx <= '0; r_wait <= '0;
            r_retry <= '0; r_kind <= C_ERR; r_cidx <= '0; r_carg <= '0;
            r_baddr <= '0; r_resp <= 8'hFF; r_left <= '0; r_ptok <= '0;
            r_rstat <= S_OK; r_rfunc <= F_BYTE; r_fast <= 1'b0; r_cto <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase; r_ret <= n_ret; r_bidx <= n_bidx; r_wait <= n_wait;
            r_retry <= n_retry; r_kind <= n_kind; r_cidx <= n_cidx; r_carg <= n_carg;
            r_baddr <= n_baddr; r_resp <= n_resp; r_left <= n_left; r_ptok <= n_ptok;
            r_rstat <= n_rstat; r_rfunc <= n_rfunc; r_fast <= n_fast; r_cto <= n_cto;
        end
    end

    // Hold CSD and response tail bytes.
    always_ff @(posedge i_clk) begin
        if (accept && csd_we) r_csd[csd_wa] <= i_rx_byte;
        if (accept && tail_we) r_tail[tail_wa] <= i_rx_byte;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_tx_byte = r_out.tx_byte;
    assign o_tx_valid = r_out.tx_valid;
    assign o_spi_fast = r_out.spi_fast;
    assign o_read_data = r_out.read_data;
    assign o_read_valid = r_out.read_valid;
    assign o_block_last = r_out.block_last;
    assign o_write_wanted = r_out.write_wanted;
    assign o_done_res = r_out.done_res;
    assign o_status = r_out.status;
    assign o_card_type = r_out.card_type;
    assign o_last_response = r_out.last_response;
    assign o_sector_count = r_out.sector_count;

    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_ovalid && r_out.done_res, !r_out.tx_valid, "done with tx")
    `ASSERT_IMPL(a_read_no_done, i_clk, i_rst_n, r_ovalid && r_out.read_valid, !r_out.done_res && r_out.tx_valid, "bad read")
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid && $stable(r_out), "result moved")
    `ASSERT_IMPL(a_bidx_range, i_clk, i_rst_n, r_phase == P_WDATA, r_bidx <= BLEN, "index past block")
endmodule

// ===== test/sd_card_spi_host_controller_tb.sv =====
`default_nettype none

module sd_card_spi_host_controller_tb;
    import sdspi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK = 512;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [2:0]  func;
        logic [7:0]  rx;
        logic [31:0] sector;
        logic [7:0]  count;
        logic [7:0]  wbyte;
        t_result     want;
    } t_xact;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_vld = 1'b0;
    logic [2:0]  in_func = F_BYTE;
    logic [7:0]  in_rx = 8'h00;
    logic [31:0] in_sector = 32'h0;
    logic [7:0]  in_count = 8'h00;
    logic [7:0]  in_wbyte = 8'h00;
    logic        out_rdy = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = R_READY_WAIT;
    logic [23:0] cfg_data = 24'h0;

    logic        o_ready, o_valid;
    logic [7:0]  o_tx_byte, o_read_data, o_last_response;
    logic        o_tx_valid, o_spi_fast, o_read_valid, o_block_last;
    logic        o_write_wanted, o_done_res;
    logic [2:0]  o_status, o_card_type;
    logic [27:0] o_sector_count;

    sd_card_spi_host_controller u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_vld), .o_ready(o_ready),
        .i_func(in_func), .i_rx_byte(in_rx), .i_sector(in_sector),
        .i_block_count(in_count), .i_write_byte(in_wbyte),
        .o_valid(o_valid), .i_ready(out_rdy),
        .o_tx_byte(o_tx_byte), .o_tx_valid(o_tx_valid), .o_spi_fast(o_spi_fast),
        .o_read_data(o_read_data), .o_read_valid(o_read_valid),
        .o_block_last(o_block_last), .o_write_wanted(o_write_wanted),
        .o_done_res(o_done_res), .o_status(o_status), .o_card_type(o_card_type),
        .o_last_response(o_last_response), .o_sector_count(o_sector_count),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Controller state mirror
    logic [23:0] lim_ready = 24'hFFFFFF;
    logic [15:0] lim_token = 16'hFFFF;
    logic [15:0] lim_retry = 16'hFFFE;
    logic [7:0]  lim_reset = 8'd20;
    logic [7:0]  lim_r1 = 8'd31;
    logic [4:0]  ph = P_IDLE, rph = K_CMD0;
    int unsigned bidx = 0, wcnt = 0;
    logic [15:0] rcnt = '0;
    logic [2:0]  kind = C_ERR, rfunc = F_BYTE;
    logic [5:0]  cidx = '0;
    logic [31:0] carg = '0, baddr = '0;
    logic [7:0]  r1b = 8'hFF, left = '0, ptok = '0, rst = '0;
    logic [7:0]  csd [16];
    logic [7:0]  tail [4];
    bit          fast = 0, cto = 0;
    t_result     res;

    t_xact   pending_xacts[$];
    t_result expected_results[$];
    int      mismatches = 0;
    int      cycles = 0;

    function automatic void emit(input logic [7:0] b);
        res.tx_byte = b;
        res.tx_valid = 1'b1;
    endfunction

    function automatic void start_cmd(input logic [5:0] idx, input logic [31:0] arg,
                                      input logic [4:0] ret);
        cidx = idx; carg = arg; rph = ret; cto = 0; ph = P_DESEL;
        emit(8'hFF);
    endfunction

    function automatic logic [7:0] cmd_byte(input int unsigned k);
        if (k == 0) return 8'h40 | {2'b00, cidx};
        if (k <= 4) return 8'(carg >> (8 * (4 - k)));
        if (cidx == 0) return 8'h95;
        if (cidx == 8) return 8'h87;
        return 8'h01;
    endfunction

    function automatic void finish_at_end(input logic [7:0] s);
        rst = s; ph = P_FINAL; emit(8'hFF);
    endfunction

    function automatic void fail_init();
        kind = C_ERR;
        finish_at_end(S_INIT_FAIL);
    endfunction

    function automatic void finish_init();
        finish_at_end(kind != C_ERR ? S_OK : S_INIT_FAIL);
    endfunction

    function automatic void begin_tail(input logic [4:0] ret);
        rph = ret; bidx = 0; ph = P_TAIL; emit(8'hFF);
    endfunction

    function automatic void begin_recv(input logic [4:0] ret);
        rph = ret; wcnt = 1; ph = P_TOKEN; emit(8'hFF);
    endfunction

    function automatic void begin_send(input logic [7:0] t, input logic [4:0] ret);
        rph = ret; ptok = t; wcnt = 1; ph = P_WRDY; emit(8'hFF);
    endfunction

    function automatic void done_now(input logic [7:0] s, input logic [27:0] n);
        ph = P_IDLE; res.done_res = 1'b1; res.status = s[2:0]; res.sector_count = n;
    endfunction

    // Capacity from the CSD, version 2 or version 1 layout
    function automatic logic [27:0] sectors_from_csd();
        logic [63:0] v;
        int unsigned n, cs;
        if (csd[0][7:6] == 2'b01) begin
            v = (64'({csd[7][5:0], csd[8], csd[9]}) + 1) << 10;
            if (v > 64'd134217728) v = 64'd134217728;
            return v[27:0];
        end
        n = csd[5][3:0] + csd[10][7] + {csd[9][1:0], 1'b0} + 2;
        cs = csd[8][7:6] + (int'(csd[7]) << 2) + (int'(csd[6][1:0]) << 10) + 1;
        return (n >= 9) ? 28'(cs << (n - 9)) : 28'(cs >> (9 - n));
    endfunction

    function automatic void retry_or_fail(input logic [5:0] idx, input logic [4:0] ret);
        rcnt = rcnt - 1;
        if (rcnt == 0) fail_init(); else start_cmd(idx, 0, ret);
    endfunction

    // Continue after a command response or a finished block
    function automatic void resume(input logic [7:0] r);
        case (rph)
            K_CMD0: begin
                rcnt = rcnt + 1;
                if (r == 8'h01) start_cmd(8, 32'h1AA, K_CMD8);
                else if (rcnt >= lim_reset) fail_init();
                else start_cmd(0, 0, K_CMD0);
            end
            K_CMD8: if (r == 8'h01) begin_tail(K_CMD8TAIL); else start_cmd(55, 0, K_V1_55A);
            K_CMD8TAIL: begin
                rcnt = lim_retry;
                if (tail[2] != 8'h01 || tail[3] != 8'hAA || rcnt == 0) fail_init();
                else start_cmd(55, 0, K_V2_55);
            end
            K_V2_55: start_cmd(41, 32'h40000000, K_V2_41);
            K_V2_41: if (r == 0) start_cmd(58, 0, K_CMD58); else retry_or_fail(55, K_V2_55);
            K_CMD58: if (r == 0) begin_tail(K_OCR); else fail_init();
            K_OCR: begin
                kind = tail[0][6] ? C_SDHC : C_SD2;
                finish_init();
            end
            K_V1_55A: start_cmd(41, 0, K_V1_41A);
            K_V1_41A: begin
                rcnt = lim_retry;
                kind = (r <= 1) ? C_SD1 : C_MMC;
                if (rcnt == 0) fail_init();
                else if (r <= 1) start_cmd(55, 0, K_V1_55);
                else start_cmd(1, 0, K_MMC1);
            end
            K_V1_55: start_cmd(41, 0, K_V1_41);
            K_V1_41: if (r == 0) start_cmd(16, BLK, K_CMD16); else retry_or_fail(55, K_V1_55);
            K_MMC1: if (r == 0) start_cmd(16, BLK, K_CMD16); else retry_or_fail(1, K_MMC1);
            K_CMD16: begin
                if (r != 0) kind = C_ERR;
                finish_init();
            end
            K_CMD9: if (r == 0) begin_recv(K_CSD); else done_now(cto ? S_RDY_TO : S_CMD_REJ, 0);
            K_CSD: if (r != 0) done_now(S_NO_TOKEN, 0); else done_now(S_OK, sectors_from_csd());
            K_RD1: if (r == 0) begin_recv(K_RDBLK1); else finish_at_end(cto ? S_RDY_TO : S_CMD_REJ);
            K_RDBLK1: finish_at_end(r != 0 ? S_NO_TOKEN : S_OK);
            K_CMD18: if (r == 0) begin_recv(K_RDBLKM); else finish_at_end(cto ? S_RDY_TO : S_CMD_REJ);
            K_RDBLKM: begin
                if (r != 0) begin
                    rst = S_NO_TOKEN; start_cmd(12, 0, K_CMD12);
                end else begin
                    left = left - 1;
                    if (left != 0) begin_recv(K_RDBLKM);
                    else begin
                        rst = S_OK; start_cmd(12, 0, K_CMD12);
                    end
                end
            end
            K_CMD12: finish_at_end(rst);
            K_W55: start_cmd(23, {24'd0, left}, K_W23);
            K_W23: start_cmd(25, baddr, K_CMD25);
            K_CMD24: if (r == 0) begin_send(TOK_SINGLE, K_WBLK1);
                     else finish_at_end(cto ? S_RDY_TO : S_CMD_REJ);
            K_WBLK1: finish_at_end(r);
            K_CMD25: begin
                rst = S_OK;
                if (r == 0) begin_send(TOK_MULTI, K_WBLKM);
                else finish_at_end(cto ? S_RDY_TO : S_CMD_REJ);
            end
            K_WBLKM: begin
                if (r != 0) begin
                    rst = r; begin_send(TOK_STOP, K_WSTOP);
                end else begin
                    left = left - 1;
                    if (left != 0) begin_send(TOK_MULTI, K_WBLKM);
                    else begin_send(TOK_STOP, K_WSTOP);
                end
            end
            default: begin
                if (rst == 0) rst = r;
                finish_at_end(rst);
            end
        endcase
    endfunction

    // Advance on the byte the card returned
    function automatic void card_byte(input logic [7:0] rx);
        int unsigned len;
        case (ph)
            P_CLK: begin
                if (bidx < 10) begin
                    bidx++; emit(8'hFF);
                end else begin
                    rcnt = 0; start_cmd(0, 0, K_CMD0);
                end
            end
            P_DESEL: begin
                wcnt = 1; ph = P_RDY; emit(8'hFF);
            end
            P_RDY: begin
                if (rx == 8'hFF) begin
                    bidx = 0; ph = P_CMD; emit(cmd_byte(0));
                end else if (wcnt >= lim_ready) begin
                    ph = P_FAILDESEL; emit(8'hFF);
                end else begin
                    wcnt++; emit(8'hFF);
                end
            end
            P_FAILDESEL: begin
                cto = 1; r1b = 8'hFF; resume(8'hFF);
            end
            P_CMD: begin
                if (bidx < 5) begin
                    bidx++; emit(cmd_byte(bidx));
                end else if (cidx == 12) begin
                    ph = P_STUFF; emit(8'hFF);
                end else begin
                    wcnt = 1; ph = P_R1; emit(8'hFF);
                end
            end
            P_STUFF: begin
                wcnt = 1; ph = P_R1; emit(8'hFF);
            end
            P_R1: begin
                if (!rx[7] || wcnt >= lim_r1) begin
                    r1b = rx; resume(rx);
                end else begin
                    wcnt++; emit(8'hFF);
                end
            end
            P_TAIL: begin
                tail[bidx & 3] = rx; bidx++;
                if (bidx < 4) emit(8'hFF); else resume(8'h00);
            end
            P_TOKEN: begin
                if (rx == TOK_SINGLE) begin
                    bidx = 0; ph = P_DATA; emit(8'hFF);
                end else if (wcnt >= lim_token) resume(8'h01);
                else begin
                    wcnt++; emit(8'hFF);
                end
            end
            P_DATA: begin
                len = (rph == K_CSD) ? 16 : BLK;
                if (rph == K_CSD) csd[bidx & 15] = rx;
                else begin
                    res.read_valid = 1'b1; res.read_data = rx;
                    res.block_last = (bidx + 1 == len);
                end
                bidx++;
                if (bidx >= len) begin
                    bidx = 0; ph = P_RCRC;
                end
                emit(8'hFF);
            end
            P_RCRC: begin
                if (bidx == 0) begin
                    bidx = 1; emit(8'hFF);
                end else resume(8'h00);
            end
            P_WRDY: begin
                if (rx == 8'hFF) begin
                    if (ptok == TOK_STOP) begin
                        ph = P_STOP; emit(TOK_STOP);
                    end else begin
                        bidx = 0; ph = P_WDATA; emit(ptok); res.write_wanted = 1'b1;
                    end
                end else if (wcnt >= lim_ready) resume(8'h01);
                else begin
                    wcnt++; emit(8'hFF);
                end
            end
            P_WDATA: begin
                if (bidx < BLK) begin
                    bidx++; res.write_wanted = (bidx < BLK);
                end else begin
                    bidx = 0; ph = P_WCRC; emit(8'hFF);
                end
            end
            P_WCRC: begin
                if (bidx == 0) begin
                    bidx = 1; emit(8'hFF);
                end else begin
                    ph = P_WRESP; emit(8'hFF);
                end
            end
            P_WRESP: resume(((rx & 8'h1F) == 8'h05) ? S_OK : S_WR_REJ);
            P_STOP: resume(8'h00);
            P_FINAL: begin
                if (rfunc == F_INIT) fast = 1;
                done_now(rst, 0);
            end
            default: ;
        endcase
    endfunction

    // Expected result of one input transaction
    function automatic t_result controller_step(input logic [2:0] f, input logic [7:0] rx,
                                                input logic [31:0] sec, input logic [7:0] cnt,
                                                input logic [7:0] wb);
        res = '0;
        if (f >= F_INIT && f <= F_CAP) begin
            rfunc = f; rst = S_OK;
            baddr = (kind == C_SDHC) ? sec : (sec << 9);
            left = cnt;
            if (f == F_INIT) begin
                fast = 0; kind = C_ERR; bidx = 1; ph = P_CLK; emit(8'hFF);
            end else if (f == F_CAP) start_cmd(9, 0, K_CMD9);
            else if (cnt == 0) done_now(S_OK, 0);
            else if (f == F_READ) begin
                if (cnt == 1) start_cmd(17, baddr, K_RD1);
                else start_cmd(18, baddr, K_CMD18);
            end else if (cnt == 1) start_cmd(24, baddr, K_CMD24);
            else if (kind >= C_SD1 && kind <= C_SDHC) start_cmd(55, 0, K_W55);
            else start_cmd(25, baddr, K_CMD25);
        end else if (ph == P_WDATA && bidx < BLK) begin
            emit(wb); card_byte(rx);
        end else if (ph != P_IDLE) begin
            card_byte(rx);
        end
        res.spi_fast = fast;
        res.card_type = kind;
        res.last_response = r1b;
        return res;
    endfunction

    // Card answer that mostly keeps the current sequence going
    function automatic logic [7:0] card_answer();
        int p;
        p = $urandom_range(0, 99);
        case (ph)
            P_RDY, P_WRDY: return (p < 85) ? 8'hFF : 8'($urandom_range(0, 254));
            P_R1: begin
                if (p < 15) return 8'hFF;
                p = $urandom_range(0, 99);
                case (rph)
                    K_CMD0: return (p < 85) ? 8'h01 : 8'($urandom);
                    K_CMD8: return (p < 75) ? 8'h01 : 8'h05;
                    K_V2_41, K_V1_41, K_MMC1: return (p < 50) ? 8'h00 : 8'h01;
                    K_V1_41A: return (p < 50) ? 8'($urandom_range(0, 1)) : 8'h05;
                    default: return (p < 90) ? 8'h00 : 8'($urandom);
                endcase
            end
            P_TAIL: begin
                if (rph == K_CMD8TAIL && bidx == 2 && p < 90) return 8'h01;
                if (rph == K_CMD8TAIL && bidx == 3 && p < 90) return 8'hAA;
                return 8'($urandom);
            end
            P_TOKEN: return (p < 70) ? TOK_SINGLE : (p < 90) ? 8'hFF : 8'($urandom);
            P_WRESP: return (p < 85) ? ((8'($urandom) & 8'hE0) | 8'h05) : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void queue_xact(input logic [2:0] f, input logic [7:0] rx,
                                       input logic [31:0] sec, input logic [7:0] cnt);
        t_xact x;
        x.func = f; x.rx = rx; x.sector = sec; x.count = cnt; x.wbyte = 8'($urandom);
        x.want = controller_step(f, rx, sec, cnt, x.wbyte);
        pending_xacts.push_back(x);
    endfunction

    function automatic void queue_card_bytes(input int n);
        logic [2:0] f;
        for (int i = 0; i < n; i++) begin
            f = ($urandom_range(0, 99) < 3) ? 3'($urandom_range(5, 7)) : F_BYTE;
            queue_xact(f, card_answer(), $urandom, 8'($urandom));
        end
    endfunction

    function automatic void run_to_idle();
        while (ph != P_IDLE) queue_card_bytes(1);
    endfunction

    function automatic logic [7:0] pick_count();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5) return 8'd0;
        if (p < 8) return 8'($urandom_range(4, 5));
        return 8'($urandom_range(1, 3));
    endfunction

    // Random traffic: requests with well-behaved card answers, some noise and aborts
    function automatic void queue_random(input int n);
        int made, p;
        logic [2:0] f;
        made = 0;
        while (made < n) begin
            p = $urandom_range(0, 99);
            if (ph == P_IDLE) begin
                if (p < 4) begin
                    queue_xact(($urandom_range(0, 1) ? F_BYTE : 3'($urandom_range(5, 7))),
                               8'($urandom), $urandom, 8'($urandom));
                    continue;
                end
                if (kind == C_ERR && p < 70) f = F_INIT;
                else begin
                    p = $urandom_range(0, 99);
                    f = (p < 30) ? F_READ : (p < 60) ? F_WRITE : (p < 85) ? F_CAP : F_INIT;
                end
                queue_xact(f, 8'($urandom), $urandom, pick_count());
            end else if (p == 0) begin
                queue_xact(3'($urandom_range(1, 4)), 8'($urandom), $urandom, pick_count());
            end else begin
                queue_card_bytes(1);
            end
            made++;
        end
        run_to_idle();
    endfunction

    // Hold until everything queued has gone through and come back
    task automatic drain();
        while (pending_xacts.size() != 0 || expected_results.size() != 0 || in_vld)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [23:0] rdy, input logic [15:0] tok,
                                input logic [15:0] rty, input logic [7:0] rtr,
                                input logic [7:0] r1p);
        logic [23:0] vals [5];
        vals = '{rdy, 24'(tok), 24'(rty), 24'(rtr), 24'(r1p)};
        for (int i = 0; i < 5; i++) begin
            @(negedge i_clk);
            cfg_we <= 1'b1;
            cfg_idx <= 3'(i);
            cfg_data <= vals[i];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        lim_ready = rdy; lim_token = tok; lim_retry = rty; lim_reset = rtr; lim_r1 = r1p;
    endtask

    // Stimulus sequence
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle noise, aborted long read, zero counts, capacity and init
        queue_xact(F_BYTE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        queue_xact(3'd7, 8'h00, 32'h0, 8'h00);
        queue_xact(F_READ, 8'hFF, 32'hFFFF_FFFF, 8'd255);
        queue_card_bytes(30);
        queue_xact(F_WRITE, 8'h00, 32'h8000_0001, 8'd0);
        queue_xact(F_READ, 8'h00, 32'h0, 8'd0);
        queue_xact(F_CAP, 8'h00, 32'h0, 8'd1);
        run_to_idle();
        queue_xact(F_INIT, 8'h00, 32'h0, 8'd1);
        run_to_idle();
        queue_xact(F_WRITE, 8'hFF, 32'hFFFF_FFFF, 8'd255);
        queue_card_bytes(40);
        queue_xact(F_READ, 8'hFF, 32'h7FFF_FFFF, 8'd1);
        run_to_idle();
        queue_random(500);
        drain();

        write_limits(24'd1, 16'd1, 16'd1, 8'd1, 8'd1);
        queue_random(500);
        drain();

        write_limits(24'd5, 16'd6, 16'd3, 8'd4, 8'd6);
        queue_random(500);
        drain();

        write_limits(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        queue_random(500);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Driver: bursts of transactions with random gaps
    logic in_fire = 1'b0;
    int   burst_left = 8, gap_left = 0;

    always @(negedge i_clk) begin
        t_xact x;
        if (!i_rst_n) begin
            in_vld <= 1'b0;
        end else if (!in_vld || in_fire) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_vld <= 1'b0;
            end else if (pending_xacts.size() != 0) begin
                x = pending_xacts.pop_front();
                in_vld <= 1'b1;
                in_func <= x.func;
                in_rx <= x.rx;
                in_sector <= x.sector;
                in_count <= x.count;
                in_wbyte <= x.wbyte;
                expected_results.push_back(x.want);
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_vld <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, reshuffled each time pat_pos wraps
    logic [15:0] stall_pat = 16'hFFFF;
    int          pat_pos = 0;

    always @(negedge i_clk) begin
        if (pat_pos == 255) begin
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        pat_pos <= (pat_pos + 1) % 256;
        out_rdy <= stall_pat[pat_pos % 16];
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        in_fire <= in_vld && o_ready;
        if (i_rst_n && o_valid && out_rdy) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, actual tx %0h", $time, o_tx_byte);
            end else begin
                e = expected_results.pop_front();
                compare_field("tx_byte", e.tx_byte, o_tx_byte);
                compare_field("tx_valid", e.tx_valid, o_tx_valid);
                compare_field("spi_fast", e.spi_fast, o_spi_fast);
                compare_field("read_data", e.read_data, o_read_data);
                compare_field("read_valid", e.read_valid, o_read_valid);
                compare_field("block_last", e.block_last, o_block_last);
                compare_field("write_wanted", e.write_wanted, o_write_wanted);
                compare_field("done_res", e.done_res, o_done_res);
                compare_field("status", e.status, o_status);
                compare_field("card_type", e.card_type, o_card_type);
                compare_field("last_response", e.last_response, o_last_response);
                compare_field("sector_count", e.sector_count, o_sector_count);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sd_card_spi_host_controller.f =====
+incdir+rtl
rtl/sdspi_pkg.sv
rtl/sd_card_spi_host_controller.sv
test/sd_card_spi_host_controller_tb.sv
